@@ design/cfrf_pkg.sv @@
package cfrf_pkg;

	// Width of one bitmap word and of a bit position inside it.
	localparam int WORD_W    = 32;
	localparam int BIT_IDX_W = 5;

	// Size of the group bitmap in bits; the port widths are built for this size.
	localparam int BITMAP_BITS = 8192;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_DATA_BITS  = 2'd0,
		CFG_BASE_BLOCK = 2'd1
	} cfg_idx_t;

	// Outcome of scanning one bitmap word.
	typedef struct packed {
		logic                 hit;
		logic [BIT_IDX_W-1:0] bit_idx;
	} cfrf_hit_t;

	// Search sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} cfrf_state_t;

endpackage

@@ design/contiguous_free_run_finder.sv @@
// Channel   Handshake                 Payload
// --------  ------------------------  ----------------------------------------
// item in   start, busy (start&!busy) kind, word_index, word_bits, run_length
// result    done, one cycle strobe    status, start_offset, first_block
// config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// A load item writes one word into the bitmap memory.
// A search of length zero or longer than the bit count returns its result
// through fin_q and the result register without reading the memory. Any other
// search reads the 256-word bitmap memory one word per cycle over its single
// read port; busy is high while it runs.
// Reset clears control state only: the bitmap memory has no clearing pass.
// Results cannot be stalled; cfg_ready is always high.
module contiguous_free_run_finder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [7:0]  word_index,
	input  logic [31:0] word_bits,
	input  logic [13:0] run_length,
	output logic        done,
	output logic        status,
	output logic [12:0] start_offset,
	output logic [31:0] first_block,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int WORDS = cfrf_pkg::BITMAP_BITS / cfrf_pkg::WORD_W;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int POS_W = $clog2(cfrf_pkg::BITMAP_BITS + 1);

	cfrf_pkg::cfrf_state_t state_q;

	logic [13:0]             data_bits_q;
	logic [31:0]             base_block_q;

	logic [POS_W-1:0]        lim_q;
	logic [POS_W-1:0]        len_q;
	logic [POS_W-1:0]        run_q;
	logic [AW-1:0]           iss_q;
	logic [AW-1:0]           last_word_q;
	logic                    issuing_q;

	logic                    v_s1;
	logic [POS_W-1:0]        wbase_s1;
	logic                    last_s1;

	logic                    fin_q;
	logic                    hit_q;
	logic [POS_W-1:0]        start_q;

	logic                    done_q;
	logic                    status_q;
	logic [12:0]             start_offset_q;
	logic [31:0]             first_block_q;

	logic                    acc;
	logic                    load_we;
	logic                    rd_en;
	logic [31:0]             rdata;
	logic [POS_W-1:0]        lim_c;
	cfrf_pkg::cfrf_hit_t     word_hit;
	logic [POS_W-1:0]        run_next;

	// Accept handshake; loads only land while no scan is reading the memory.
	assign busy      = (state_q == cfrf_pkg::ST_SCAN);
	assign acc       = start && !busy;
	assign load_we   = acc && !kind && (32'(word_index) < 32'(WORDS));
	assign rd_en     = busy && issuing_q;
	assign cfg_ready = 1'b1;

	// Effective bit count, saturated to the bitmap size.
	assign lim_c = (32'(data_bits_q) > 32'(cfrf_pkg::BITMAP_BITS))
		? POS_W'(cfrf_pkg::BITMAP_BITS) : POS_W'(data_bits_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bits_q  <= 14'd8192;
			base_block_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfrf_pkg::cfg_idx_t'(cfg_index))
				cfrf_pkg::CFG_DATA_BITS:  data_bits_q  <= cfg_data[13:0];
				cfrf_pkg::CFG_BASE_BLOCK: base_block_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cfrf_bitmap_mem #(
		.DEPTH (WORDS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(word_index)),
		.wdata (word_bits),
		.re    (rd_en),
		.raddr (iss_q),
		.rdata (rdata)
	);

	cfrf_word_eval #(
		.POS_W (POS_W)
	) u_eval (
		.word    (rdata),
		.run_in  (run_q),
		.len     (len_q),
		.lim     (lim_q),
		.wbase   (wbase_s1),
		.hit     (word_hit),
		.run_out (run_next)
	);

	// Scan sequencer: issues one word read per cycle and evaluates the word read
	// in the cycle before; zero-length and too-long searches skip the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cfrf_pkg::ST_IDLE;
			issuing_q   <= 1'b0;
			v_s1        <= 1'b0;
			fin_q       <= 1'b0;
			hit_q       <= 1'b0;
			start_q     <= '0;
			lim_q       <= '0;
			len_q       <= '0;
			run_q       <= '0;
			iss_q       <= '0;
			last_word_q <= '0;
			wbase_s1    <= '0;
			last_s1     <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			unique case (state_q)
				cfrf_pkg::ST_IDLE: begin
					if (acc && kind) begin
						if (run_length == '0) begin
							fin_q   <= 1'b1;
							hit_q   <= 1'b1;
							start_q <= '0;
						end else if (32'(run_length) > 32'(lim_c)) begin
							fin_q   <= 1'b1;
							hit_q   <= 1'b0;
							start_q <= '0;
						end else begin
							state_q     <= cfrf_pkg::ST_SCAN;
							lim_q       <= lim_c;
							len_q       <= POS_W'(run_length);
							run_q       <= '0;
							iss_q       <= '0;
							last_word_q <= AW'((lim_c - POS_W'(1)) >> cfrf_pkg::BIT_IDX_W);
							issuing_q   <= 1'b1;
							v_s1        <= 1'b0;
						end
					end
				end
				cfrf_pkg::ST_SCAN: begin
					// Read issue.
					v_s1 <= issuing_q;
					if (issuing_q) begin
						wbase_s1 <= POS_W'({iss_q, {cfrf_pkg::BIT_IDX_W{1'b0}}});
						last_s1  <= (iss_q == last_word_q);
						iss_q    <= iss_q + AW'(1);
						if (iss_q == last_word_q) begin
							issuing_q <= 1'b0;
						end
					end
					// Word evaluation.
					if (v_s1) begin
						if (word_hit.hit || last_s1) begin
							state_q   <= cfrf_pkg::ST_IDLE;
							issuing_q <= 1'b0;
							v_s1      <= 1'b0;
							fin_q     <= 1'b1;
							hit_q     <= word_hit.hit;
							start_q   <= wbase_s1 + POS_W'(word_hit.bit_idx) + POS_W'(1)
								- len_q;
						end else begin
							run_q <= run_next;
						end
					end
				end
				default: begin
					state_q   <= cfrf_pkg::ST_IDLE;
					issuing_q <= 1'b0;
					v_s1      <= 1'b0;
				end
			endcase
		end
	end

	// Result register: adds the group base and drives the strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_q) begin
			status_q       <= !hit_q;
			start_offset_q <= hit_q ? 13'(start_q) : '0;
			first_block_q  <= hit_q ? (base_block_q + 32'(start_q)) : '0;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign start_offset = start_offset_q;
	assign first_block  = first_block_q;

endmodule

@@ design/cfrf_bitmap_mem.sv @@
module cfrf_bitmap_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [cfrf_pkg::WORD_W-1:0]  wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic [cfrf_pkg::WORD_W-1:0]  rdata
);

	logic [cfrf_pkg::WORD_W-1:0] mem [DEPTH];

	// One write port for bitmap loads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// One read port with registered data for the scan.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/cfrf_word_eval.sv @@
module cfrf_word_eval #(
	parameter int POS_W = 14
) (
	input  logic [cfrf_pkg::WORD_W-1:0] word,
	input  logic [POS_W-1:0]            run_in,
	input  logic [POS_W-1:0]            len,
	input  logic [POS_W-1:0]            lim,
	input  logic [POS_W-1:0]            wbase,
	output cfrf_pkg::cfrf_hit_t         hit,
	output logic [POS_W-1:0]            run_out
);

	// Each bit position works out its own free-run length from the last used
	// bit at or below it, or from the run carried in when there is none.
	// The lowest valid position whose run reaches the wanted length wins.
	always_comb begin
		logic                           seen;
		logic [cfrf_pkg::BIT_IDX_W-1:0] last;
		logic [POS_W-1:0]               run_j;
		logic                           valid_j;
		hit     = '0;
		run_out = '0;
		for (int j = 0; j < cfrf_pkg::WORD_W; j++) begin
			seen = 1'b0;
			last = '0;
			for (int i = 0; i <= j; i++) begin
				if (word[i]) begin
					seen = 1'b1;
					last = cfrf_pkg::BIT_IDX_W'(i);
				end
			end
			if (seen) begin
				run_j = POS_W'(j) - POS_W'(last);
			end else begin
				run_j = run_in + POS_W'(j + 1);
			end
			valid_j = (wbase + POS_W'(j)) < lim;
			if (valid_j && (run_j >= len) && !hit.hit) begin
				hit.hit     = 1'b1;
				hit.bit_idx = cfrf_pkg::BIT_IDX_W'(j);
			end
			if (j == cfrf_pkg::WORD_W - 1) begin
				run_out = run_j;
			end
		end
	end

endmodule

@@ design/cfrf_checker.sv @@
module cfrf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        kind,
	input logic [13:0] run_length,
	input logic        done,
	input logic        status,
	input logic [12:0] start_offset,
	input logic [31:0] first_block
);

	// A scan only begins from an accepted search item.
	a_busy_from_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && kind))
		else $error("busy rose without an accepted search item");

	// The end of a scan always delivers a result through the done strobe register.
	a_scan_ends_in_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |=> done)
		else $error("scan ended without a result");

	// A failed search reports zero offset and block.
	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (start_offset == '0 && first_block == '0))
		else $error("failed search returned nonzero fields");

	// A load item never produces a result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !kind) |-> ##2 !done)
		else $error("load item produced a result");

	// A zero-length search succeeds at offset zero.
	a_zero_length: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind && run_length == '0) |->
		##2 (done && !status && start_offset == '0))
		else $error("zero-length search did not succeed at offset zero");

endmodule

bind contiguous_free_run_finder cfrf_checker u_cfrf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.kind         (kind),
	.run_length   (run_length),
	.done         (done),
	.status       (status),
	.start_offset (start_offset),
	.first_block  (first_block)
);
